FILE: rtl/stpd_pkg.sv
// Shared types, constants and the table index function of the pixel denoiser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package stpd_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int TABLE_ENTRIES  = 8192;
   localparam int TBL_AW         = $clog2(TABLE_ENTRIES);

   localparam int PIX_BITS       = 8;
   localparam int ACC_BITS       = 26;
   localparam int HIST_BITS      = 16;
   localparam int CFG_DIM_BITS   = 11;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int OUT_DEPTH      = 8;

   localparam logic [CFG_DIM_BITS-1:0] DIM_RESET = 11'd1024;

   // input operations
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // coefficient table select
   localparam logic TSEL_SPATIAL  = 1'b0;
   localparam logic TSEL_TEMPORAL = 1'b1;

   // register index (paddr bit 2)
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [27:0]         LP_OFFSET  = 28'h10007FF;
   localparam logic [ACC_BITS-1:0] HIST_ROUND = 26'h000007F;
   localparam logic [ACC_BITS-1:0] OUT_ROUND  = 26'h0007FFF;

   typedef logic signed [ACC_BITS-1:0] acc_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] pix;
      logic                col0;
      logic                row0;
      logic                first;
      logic                last;
   } pinfo_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel_out;
      logic                frame_end;
   } out_word_type;

   // Table address for one recursive step: (prev - cur + offset) / 4096, clamped.
   function automatic logic [TBL_AW-1:0] lp_index(input acc_type prev, input acc_type cur);
      logic [27:0] s;
      logic [TBL_AW-1:0] idx;
      s = {{2{prev[ACC_BITS-1]}}, prev} - {{2{cur[ACC_BITS-1]}}, cur} + LP_OFFSET;
      if (s[27]) begin
         idx = '0;
      end else if (|s[26:25]) begin
         idx = '1;
      end else begin
         idx = s[24:12];
      end
      return idx;
   endfunction

   function automatic acc_type pix_to_acc(input logic [PIX_BITS-1:0] pix);
      return {2'b00, pix, 16'h0000};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/stpd_req_if.sv
// Input channel of the pixel denoiser: pixels to filter and table loads.
// Depends on stpd_pkg for field widths.
`default_nettype none

interface stpd_req_if;
   import stpd_pkg::*;

   logic                valid;
   logic                ready;
   logic                operation;
   logic [PIX_BITS-1:0] pixel_in;
   logic                table_select;
   logic [TBL_AW-1:0]   coef_index;
   acc_type             coef_value;

   modport source (output valid, operation, pixel_in, table_select, coef_index, coef_value,
                   input ready);
   modport sink   (input valid, operation, pixel_in, table_select, coef_index, coef_value,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/stpd_rsp_if.sv
// Result channel of the pixel denoiser: one filtered pixel per word.
// Depends on stpd_pkg for field widths.
`default_nettype none

interface stpd_rsp_if;
   import stpd_pkg::*;

   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] pixel_out;
   logic                frame_end;

   modport source (output valid, pixel_out, frame_end, input ready);
   modport sink   (input valid, pixel_out, frame_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/spatio_temporal_pixel_denoiser.sv
// Channel  Dir  Handshake             Payload
// req      in   valid/ready           operation, pixel_in, table_select, coef_index, coef_value
// rsp      out  valid/ready           pixel_out, frame_end
// apb      in   psel/penable/pready   image_width @ 0x0, image_height @ 0x4
//
// A new pixel is not taken while the previous one is in the first stage, as set by the horizontal
// recursion: spatial table read plus add before the next pixel's table address is known.
// A table load is written at once when no pixel still has a table read ahead of it,
// else held (input not ready) until the last such pixel issues its temporal read.
// Reset clears control only; tables, line store and history are not cleared.
// An 8-word output queue absorbs stalls; input ready drops when in-flight plus queued
// words reach 8, so the 7-stage pipeline itself never stalls.
// Depends on stpd_pkg, stpd_req_if and stpd_rsp_if.
`default_nettype none

module spatio_temporal_pixel_denoiser #(
   parameter int MAX_WIDTH  = stpd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = stpd_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   stpd_req_if.sink                                req,
   stpd_rsp_if.source                              rsp,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [stpd_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [stpd_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [stpd_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                    pready
);
   import stpd_pkg::*;

   localparam int XB         = $clog2(MAX_WIDTH);
   localparam int YB         = $clog2(MAX_HEIGHT);
   localparam int HIST_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int PB         = $clog2(HIST_DEPTH);
   localparam int QB         = $clog2(OUT_DEPTH);
   localparam int CB         = $clog2(OUT_DEPTH + 1);

   // ---------------------------------------------------------------- memories
   acc_type                spat_mem [TABLE_ENTRIES];
   acc_type                temp_mem [TABLE_ENTRIES];
   acc_type                ls_mem   [MAX_WIDTH];
   logic [HIST_BITS-1:0]   hist_mem [HIST_DEPTH];
   out_word_type           out_q_ff [OUT_DEPTH];

   // ---------------------------------------------------------------- registers
   logic [CFG_DIM_BITS-1:0] cfg_width_ff, cfg_width_in;
   logic [CFG_DIM_BITS-1:0] cfg_height_ff, cfg_height_in;
   logic [XB-1:0]           col_ff, col_in;
   logic [YB-1:0]           row_ff, row_in;
   logic [PB-1:0]           pos_cnt_ff, pos_cnt_in;
   logic                    first_ff, first_in;

   logic [7:1]              vld_ff, vld_in;
   pinfo_type               info_ff [1:7];
   pinfo_type               info_in [1:7];
   logic [XB-1:0]           x_ff    [1:4];
   logic [XB-1:0]           x_in    [1:4];
   logic [PB-1:0]           pos_ff  [1:6];
   logic [PB-1:0]           pos_in  [1:6];

   acc_type                 left_acc_ff, left_acc_in;
   acc_type                 h3_ff, h3_in;
   acc_type                 h4_ff, h4_in;
   acc_type                 v5_ff, v5_in;
   acc_type                 v6_ff, v6_in;
   acc_type                 dst7_ff, dst7_in;
   acc_type                 sa_rd_ff, sb_rd_ff, t_rd_ff, ls_rd_ff;
   logic [HIST_BITS-1:0]    hist_rd_ff;

   logic                    ld_pend_ff, ld_pend_in;
   logic                    ld_sel_ff, ld_sel_in;
   logic [TBL_AW-1:0]       ld_addr_ff, ld_addr_in;
   acc_type                 ld_val_ff, ld_val_in;

   logic [QB-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [QB-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0]           q_cnt_ff, q_cnt_in;
   logic [CB-1:0]           inflight_ff, inflight_in;

   // ---------------------------------------------------------------- comb signals
   logic                    cfg_wr;
   logic                    req_acc, px_acc, ld_acc;
   logic                    credit_ok, tbl_clear;
   logic [XB-1:0]           last_col;
   logic [YB-1:0]           last_row;
   logic                    col_last, row_last;
   logic [TBL_AW-1:0]       sa_addr, sb_addr, t_addr;
   acc_type                 left_c2, v_c4, dst_c6, hsum_c6, osum_c7;
   logic [HIST_BITS-1:0]    hist_c5, hist_w;
   logic                    tw_en;
   logic                    tw_sel;
   logic [TBL_AW-1:0]       tw_addr;
   acc_type                 tw_val;
   logic                    q_push, q_pop;

   // ---------------------------------------------------------------- config port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      if (paddr[CSR_ADDR_BITS-1] == REG_IMAGE_HEIGHT) begin
         prdata = {{(CSR_DATA_BITS-CFG_DIM_BITS){1'b0}}, cfg_height_ff};
      end else begin
         prdata = {{(CSR_DATA_BITS-CFG_DIM_BITS){1'b0}}, cfg_width_ff};
      end
   end

   // clamp geometry to 1..MAX
   always_comb begin
      if (cfg_width_ff == '0) begin
         last_col = '0;
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         last_col = XB'(MAX_WIDTH - 1);
      end else begin
         last_col = XB'(cfg_width_ff - 1'b1);
      end
      if (cfg_height_ff == '0) begin
         last_row = '0;
      end else if (32'(cfg_height_ff) > MAX_HEIGHT) begin
         last_row = YB'(MAX_HEIGHT - 1);
      end else begin
         last_row = YB'(cfg_height_ff - 1'b1);
      end
   end

   assign col_last = (col_ff == last_col);
   assign row_last = (row_ff == last_row);

   // ---------------------------------------------------------------- handshake
   assign credit_ok = ({1'b0, inflight_ff} + {1'b0, q_cnt_ff}) < (CB + 1)'(OUT_DEPTH);
   assign req.ready = !vld_ff[1] && !ld_pend_ff && credit_ok;
   assign req_acc   = req.valid && req.ready;
   assign px_acc    = req_acc && (req.operation == OP_FILTER);
   assign ld_acc    = req_acc && (req.operation == OP_LOAD);

   // no pixel left that still reads a table
   assign tbl_clear = ~|vld_ff[5:1];

   assign tw_en   = tbl_clear && (ld_pend_ff || ld_acc);
   assign tw_sel  = ld_pend_ff ? ld_sel_ff  : req.table_select;
   assign tw_addr = ld_pend_ff ? ld_addr_ff : req.coef_index;
   assign tw_val  = ld_pend_ff ? ld_val_ff  : req.coef_value;

   // ---------------------------------------------------------------- datapath
   // c1: horizontal address, c2: horizontal add
   assign sa_addr = lp_index(left_acc_ff, pix_to_acc(info_ff[1].pix));
   assign left_c2 = info_ff[2].col0 ? pix_to_acc(info_ff[2].pix)
                                    : pix_to_acc(info_ff[2].pix) + sa_rd_ff;
   // c3: vertical address, c4: vertical add
   assign sb_addr = lp_index(ls_rd_ff, h3_ff);
   assign v_c4    = info_ff[4].row0 ? h4_ff : h4_ff + sb_rd_ff;
   // c5: temporal address, c6: temporal add and history word
   assign hist_c5 = info_ff[5].first ? {info_ff[5].pix, 8'h00} : hist_rd_ff;
   assign t_addr  = lp_index({2'b00, hist_c5, 8'h00}, v5_ff);
   assign dst_c6  = v6_ff + t_rd_ff;
   assign hsum_c6 = dst_c6 + HIST_ROUND;
   assign hist_w  = hsum_c6[23:8];
   // c7: rounded output
   assign osum_c7 = dst7_ff + OUT_ROUND;

   assign q_push = vld_ff[7];
   assign q_pop  = rsp.valid && rsp.ready;

   always_comb begin
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      pos_cnt_in    = pos_cnt_ff;
      first_in      = first_ff;

      if (cfg_wr) begin
         if (paddr[CSR_ADDR_BITS-1] == REG_IMAGE_HEIGHT) begin
            cfg_height_in = pwdata[CFG_DIM_BITS-1:0];
         end else begin
            cfg_width_in = pwdata[CFG_DIM_BITS-1:0];
         end
         col_in     = '0;
         row_in     = '0;
         pos_cnt_in = '0;
         first_in   = 1'b1;
      end else if (px_acc) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in     = '0;
               pos_cnt_in = '0;
               first_in   = 1'b0;
            end else begin
               row_in     = row_ff + 1'b1;
               pos_cnt_in = pos_cnt_ff + 1'b1;
            end
         end else begin
            col_in     = col_ff + 1'b1;
            pos_cnt_in = pos_cnt_ff + 1'b1;
         end
      end

      // pipeline advances every cycle
      vld_in = {vld_ff[6:1], px_acc};
      info_in[1].pix   = req.pixel_in;
      info_in[1].col0  = (col_ff == '0);
      info_in[1].row0  = (row_ff == '0);
      info_in[1].first = first_ff;
      info_in[1].last  = col_last && row_last;
      for (int k = 2; k <= 7; k++) begin
         info_in[k] = info_ff[k-1];
      end
      x_in[1] = col_ff;
      for (int k = 2; k <= 4; k++) begin
         x_in[k] = x_ff[k-1];
      end
      pos_in[1] = pos_cnt_ff;
      for (int k = 2; k <= 6; k++) begin
         pos_in[k] = pos_ff[k-1];
      end

      left_acc_in = vld_ff[2] ? left_c2 : left_acc_ff;
      h3_in       = left_c2;
      h4_in       = h3_ff;
      v5_in       = v_c4;
      v6_in       = v5_ff;
      dst7_in     = dst_c6;

      // hold a load until earlier pixels are done with the tables
      ld_pend_in = ld_pend_ff ? !tbl_clear : (ld_acc && !tbl_clear);
      ld_sel_in  = ld_acc ? req.table_select : ld_sel_ff;
      ld_addr_in = ld_acc ? req.coef_index   : ld_addr_ff;
      ld_val_in  = ld_acc ? req.coef_value   : ld_val_ff;

      wr_ptr_in   = q_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in   = q_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      q_cnt_in    = q_cnt_ff + CB'(q_push) - CB'(q_pop);
      inflight_in = inflight_ff + CB'(px_acc) - CB'(q_push);
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= DIM_RESET;
         cfg_height_ff <= DIM_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         pos_cnt_ff    <= '0;
         first_ff      <= 1'b1;
         vld_ff        <= '0;
         left_acc_ff   <= '0;
         ld_pend_ff    <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         q_cnt_ff      <= '0;
         inflight_ff   <= '0;
      end else begin
         cfg_width_ff  <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pos_cnt_ff    <= pos_cnt_in;
         first_ff      <= first_in;
         vld_ff        <= vld_in;
         left_acc_ff   <= left_acc_in;
         ld_pend_ff    <= ld_pend_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         q_cnt_ff      <= q_cnt_in;
         inflight_ff   <= inflight_in;
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      info_ff <= info_in;
      x_ff    <= x_in;
      pos_ff  <= pos_in;
      h3_ff   <= h3_in;
      h4_ff   <= h4_in;
      v5_ff   <= v5_in;
      v6_ff   <= v6_in;
      dst7_ff <= dst7_in;
      ld_sel_ff  <= ld_sel_in;
      ld_addr_ff <= ld_addr_in;
      ld_val_ff  <= ld_val_in;
   end

   // ---------------------------------------------------------------- coefficient tables
   always_ff @(posedge clock) begin
      if (tw_en && (tw_sel == TSEL_SPATIAL)) begin
         spat_mem[tw_addr] <= tw_val;
      end
      sa_rd_ff <= spat_mem[sa_addr];
      sb_rd_ff <= spat_mem[sb_addr];
   end

   always_ff @(posedge clock) begin
      if (tw_en && (tw_sel == TSEL_TEMPORAL)) begin
         temp_mem[tw_addr] <= tw_val;
      end
      t_rd_ff <= temp_mem[t_addr];
   end

   // ---------------------------------------------------------------- line store
   // forward the word written at the same edge (single-column lines)
   always_ff @(posedge clock) begin
      if (vld_ff[4]) begin
         ls_mem[x_ff[4]] <= v_c4;
      end
      if (vld_ff[4] && (x_ff[4] == x_ff[2])) begin
         ls_rd_ff <= v_c4;
      end else begin
         ls_rd_ff <= ls_mem[x_ff[2]];
      end
   end

   // ---------------------------------------------------------------- history frame
   // forward the word written at the same edge (tiny frames)
   always_ff @(posedge clock) begin
      if (vld_ff[6]) begin
         hist_mem[pos_ff[6]] <= hist_w;
      end
      if (vld_ff[6] && (pos_ff[6] == pos_ff[4])) begin
         hist_rd_ff <= hist_w;
      end else begin
         hist_rd_ff <= hist_mem[pos_ff[4]];
      end
   end

   // ---------------------------------------------------------------- output queue
   always_ff @(posedge clock) begin
      if (q_push) begin
         out_q_ff[wr_ptr_ff] <= '{pixel_out: osum_c7[23:16], frame_end: info_ff[7].last};
      end
   end

   assign rsp.valid     = (q_cnt_ff != '0);
   assign rsp.pixel_out = out_q_ff[rd_ptr_ff].pixel_out;
   assign rsp.frame_end = out_q_ff[rd_ptr_ff].frame_end;

   // ---------------------------------------------------------------- assertions
   a_px_spacing : assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |=> !vld_ff[1])
      else $error("pixels entered the pipeline on adjacent cycles");

   a_tbl_write_safe : assert property (@(posedge clock) disable iff (reset)
      tw_en |-> (vld_ff[5:1] == '0))
      else $error("table written while a pixel still reads it");

   a_inflight_count : assert property (@(posedge clock) disable iff (reset)
      32'(inflight_ff) == $countones(vld_ff))
      else $error("in-flight count disagrees with pipeline occupancy");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      ({1'b0, inflight_ff} + {1'b0, q_cnt_ff}) <= (CB + 1)'(OUT_DEPTH))
      else $error("output queue could overflow");

endmodule

`default_nettype wire
